// ----- rtl/core/integer_field_formatter_macros.svh -----
// Assertion macros for the integer field formatter checker.
`ifndef INTEGER_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_MACROS_SVH

// same-cycle implication
`define IFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/iff_pkg.sv -----
// Types, constants and helper functions of the integer field formatter.
`default_nettype none
package iff_pkg;

  localparam int MAX_FIELD = 64;
  localparam int CNT_W     = $clog2(MAX_FIELD + 1);
  localparam int VAL_W     = 64;
  localparam int DIGITS    = 22;
  localparam int DIG_W     = 4;
  localparam int IDX_W     = $clog2(DIGITS);
  localparam int BITCNT_W  = $clog2(VAL_W);
  localparam int LEN_W     = 9;
  localparam int BCD_W     = DIGITS * DIG_W;

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;

  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;
  localparam logic [1:0] SZ_64 = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } iff_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  size_code;
    logic [1:0]  sign_mode;
    logic        left_justify;
    logic        zero_pad;
    logic        alternate;
    logic [6:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
  } iff_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } iff_out_t;

  function automatic logic [BCD_W-1:0] digits_octal(input logic [VAL_W-1:0] v);
    logic [DIGITS*3-1:0] vx;
    logic [BCD_W-1:0]    r;
    vx = {{(DIGITS*3-VAL_W){1'b0}}, v};
    for (int i = 0; i < DIGITS; i++) begin
      r[i*DIG_W +: DIG_W] = {1'b0, vx[i*3 +: 3]};
    end
    return r;
  endfunction

  function automatic logic [BCD_W-1:0] digits_hex(input logic [VAL_W-1:0] v);
    return {{(BCD_W-VAL_W){1'b0}}, v};
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
    logic [7:0] dx;
    dx = {{(8-DIG_W){1'b0}}, d};
    if (d < DIG_W'(10)) begin
      return CH_ZERO + dx;
    end
    return (upper ? CH_UP_A : CH_LOW_A) + dx - 8'd10;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/integer_field_formatter.sv -----
// Top level of the integer field formatter: sequencer and field datapath.
//
//   channel | ports                      | moves
//   --------+----------------------------+--------------------------------
//   input   | in_valid in_ready in_data  | one conversion request
//   output  | out_valid out_ready out_data | one character with last flag
//
// Decimal requests go through the shift-and-add-3 loop; octal and hex skip it.
// The digit scan then strips leading zeros, the sizing step sets padding and length,
// and the emit phase sends the characters while the output register has space.
// Reset clears the sequencer and the output register; no clearing pass.
// A stalled consumer holds the sequencer in the emit phase; the last character may
// wait in the output register while the next request is taken.
`default_nettype none
module integer_field_formatter
  import iff_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire iff_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output iff_out_t     out_data
);

  iff_state_t state_r, state_nxt;

  logic [2:0]          kind_r, kind_nxt;
  logic                left_r, left_nxt;
  logic                zfill_r, zfill_nxt;
  logic                hasp_r, hasp_nxt;
  logic [5:0]          prec_r, prec_nxt;
  logic [CNT_W-1:0]    width_r, width_nxt;
  logic [VAL_W-1:0]    value_r, value_nxt;
  logic [BCD_W-1:0]    dig_r, dig_nxt;
  logic [BITCNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [1:0]          np_r, np_nxt;
  logic [7:0]          pre0_r, pre0_nxt;
  logic [7:0]          pre1_r, pre1_nxt;
  logic                ozp_r, ozp_nxt;
  logic                vzero_r, vzero_nxt;
  logic [CNT_W-1:0]    lpad_r, lpad_nxt;
  logic [1:0]          pre_left_r, pre_left_nxt;
  logic [CNT_W-1:0]    zero_left_r, zero_left_nxt;
  logic [IDX_W:0]      dig_left_r, dig_left_nxt;
  logic [CNT_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;

  logic [BCD_W-1:0] dabble_out;
  logic             space;
  logic             push;
  iff_out_t         push_data;

  logic [2:0]        kind_eff;
  logic [VAL_W-1:0]  mask;
  logic [VAL_W-1:0]  vm;
  logic              sbit;
  logic              neg;
  logic              prec0_in;
  logic [DIG_W-1:0]  cur_dig;

  logic signed [LEN_W-1:0] nd_s, np_s, w_s, p_s, nz_s, nz_c, nchar_s, npad_s, tot_s, len_s;
  logic [IDX_W:0]          nd;

  iff_dabble_unit u_dabble (
    .bcd_i (dig_r),
    .bit_i (value_r[VAL_W-1]),
    .bcd_o (dabble_out)
  );

  iff_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign cur_dig  = dig_r[idx_r*DIG_W +: DIG_W];

  always_comb begin
    kind_eff = (in_data.kind > KIND_HEXU) ? KIND_UDEC : in_data.kind;
    unique case (in_data.size_code)
      SZ_8: begin
        mask = {{(VAL_W-8){1'b0}}, 8'hff};
        sbit = in_data.value[7];
      end
      SZ_16: begin
        mask = {{(VAL_W-16){1'b0}}, 16'hffff};
        sbit = in_data.value[15];
      end
      SZ_32: begin
        mask = {{(VAL_W-32){1'b0}}, 32'hffff_ffff};
        sbit = in_data.value[31];
      end
      SZ_64: begin
        mask = {VAL_W{1'b1}};
        sbit = in_data.value[VAL_W-1];
      end
      default: begin
        mask = {VAL_W{1'b1}};
        sbit = in_data.value[VAL_W-1];
      end
    endcase
    vm       = in_data.value & mask;
    neg      = (kind_eff == KIND_SDEC) && sbit;
    prec0_in = in_data.has_precision && (in_data.min_digits == 6'd0);
  end

  always_comb begin
    nd      = (vzero_r && hasp_r && (prec_r == 6'd0)) ? '0 : ({1'b0, idx_r} + 1'b1);
    nd_s    = LEN_W'(nd);
    np_s    = LEN_W'(np_r);
    w_s     = LEN_W'(width_r);
    p_s     = LEN_W'(prec_r);
    if (zfill_r) begin
      nz_s = w_s - nd_s - np_s;
    end else if (hasp_r) begin
      nz_s = p_s - nd_s - LEN_W'(ozp_r);
    end else begin
      nz_s = '0;
    end
    nz_c    = nz_s[LEN_W-1] ? '0 : nz_s;
    nchar_s = nd_s + nz_c + np_s;
    npad_s  = w_s - nchar_s;
    if (npad_s[LEN_W-1]) begin
      npad_s = '0;
    end
    tot_s   = (w_s > nchar_s) ? w_s : nchar_s;
    len_s   = (tot_s > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : tot_s;
    if (nz_c > LEN_W'(MAX_FIELD)) begin
      nz_c = LEN_W'(MAX_FIELD);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    zfill_nxt     = zfill_r;
    hasp_nxt      = hasp_r;
    prec_nxt      = prec_r;
    width_nxt     = width_r;
    value_nxt     = value_r;
    dig_nxt       = dig_r;
    bitcnt_nxt    = bitcnt_r;
    idx_nxt       = idx_r;
    np_nxt        = np_r;
    pre0_nxt      = pre0_r;
    pre1_nxt      = pre1_r;
    ozp_nxt       = ozp_r;
    vzero_nxt     = vzero_r;
    lpad_nxt      = lpad_r;
    pre_left_nxt  = pre_left_r;
    zero_left_nxt = zero_left_r;
    dig_left_nxt  = dig_left_r;
    emit_cnt_nxt  = emit_cnt_r;
    len_nxt       = len_r;
    push          = 1'b0;
    push_data     = '{out_char: CH_SPACE, last: 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt   = kind_eff;
          left_nxt   = in_data.left_justify;
          zfill_nxt  = in_data.zero_pad && !in_data.left_justify && !in_data.has_precision;
          hasp_nxt   = in_data.has_precision;
          prec_nxt   = in_data.min_digits;
          width_nxt  = (in_data.field_width > 7'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                            : CNT_W'(in_data.field_width);
          value_nxt  = neg ? (~(vm | ~mask) + 1'b1) : vm;
          vzero_nxt  = (vm == '0);
          bitcnt_nxt = '0;
          idx_nxt    = IDX_W'(DIGITS - 1);
          np_nxt     = 2'd0;
          ozp_nxt    = 1'b0;
          pre0_nxt   = CH_ZERO;
          pre1_nxt   = CH_LOW_X;
          unique case (kind_eff)
            KIND_SDEC: begin
              if (neg) begin
                np_nxt   = 2'd1;
                pre0_nxt = CH_MINUS;
              end else if (in_data.sign_mode == SIGN_PLUS) begin
                np_nxt   = 2'd1;
                pre0_nxt = CH_PLUS;
              end else if (in_data.sign_mode == SIGN_SPACE) begin
                np_nxt   = 2'd1;
                pre0_nxt = CH_SPACE;
              end
            end
            KIND_OCT: begin
              if (in_data.alternate && ((vm != '0) || prec0_in)) begin
                np_nxt  = 2'd1;
                ozp_nxt = 1'b1;
              end
            end
            KIND_HEXL, KIND_HEXU: begin
              if (in_data.alternate && (vm != '0)) begin
                np_nxt   = 2'd2;
                pre1_nxt = (kind_eff == KIND_HEXU) ? CH_UP_X : CH_LOW_X;
              end
            end
            default: begin
            end
          endcase
          priority if (kind_eff == KIND_OCT) begin
            dig_nxt   = digits_octal(vm);
            state_nxt = ST_SCAN;
          end else if ((kind_eff == KIND_HEXL) || (kind_eff == KIND_HEXU)) begin
            dig_nxt   = digits_hex(vm);
            state_nxt = ST_SCAN;
          end else begin
            dig_nxt   = '0;
            state_nxt = ST_CONVERT;
          end
        end
      end
      ST_CONVERT: begin
        dig_nxt    = dabble_out;
        value_nxt  = {value_r[VAL_W-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 1'b1;
        if (bitcnt_r == BITCNT_W'(VAL_W - 1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((cur_dig == '0) && (idx_r != '0)) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        lpad_nxt      = left_r ? '0 : CNT_W'(npad_s);
        pre_left_nxt  = np_r;
        zero_left_nxt = CNT_W'(nz_c);
        dig_left_nxt  = nd;
        emit_cnt_nxt  = '0;
        len_nxt       = CNT_W'(len_s);
        state_nxt     = (len_s == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (space) begin
          push           = 1'b1;
          push_data.last = (emit_cnt_r == (len_r - 1'b1));
          priority if (lpad_r != '0) begin
            push_data.out_char = CH_SPACE;
            lpad_nxt = lpad_r - 1'b1;
          end else if (pre_left_r != 2'd0) begin
            push_data.out_char = (pre_left_r == np_r) ? pre0_r : pre1_r;
            pre_left_nxt = pre_left_r - 1'b1;
          end else if (zero_left_r != '0) begin
            push_data.out_char = CH_ZERO;
            zero_left_nxt = zero_left_r - 1'b1;
          end else if (dig_left_r != '0) begin
            push_data.out_char = digit_char(cur_dig, kind_r == KIND_HEXU);
            dig_left_nxt = dig_left_r - 1'b1;
            if (idx_r != '0) begin
              idx_nxt = idx_r - 1'b1;
            end
          end else begin
            push_data.out_char = CH_SPACE;
          end
          emit_cnt_nxt = emit_cnt_r + 1'b1;
          if (push_data.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    left_r      <= left_nxt;
    zfill_r     <= zfill_nxt;
    hasp_r      <= hasp_nxt;
    prec_r      <= prec_nxt;
    width_r     <= width_nxt;
    value_r     <= value_nxt;
    dig_r       <= dig_nxt;
    bitcnt_r    <= bitcnt_nxt;
    idx_r       <= idx_nxt;
    np_r        <= np_nxt;
    pre0_r      <= pre0_nxt;
    pre1_r      <= pre1_nxt;
    ozp_r       <= ozp_nxt;
    vzero_r     <= vzero_nxt;
    lpad_r      <= lpad_nxt;
    pre_left_r  <= pre_left_nxt;
    zero_left_r <= zero_left_nxt;
    dig_left_r  <= dig_left_nxt;
    emit_cnt_r  <= emit_cnt_nxt;
    len_r       <= len_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/iff_dabble_unit.sv -----
// Shared shift-and-add-3 step for binary to BCD conversion.
`default_nettype none
module iff_dabble_unit
  import iff_pkg::*;
(
  input  wire logic [BCD_W-1:0] bcd_i,
  input  wire logic             bit_i,
  output logic      [BCD_W-1:0] bcd_o
);

  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[i*DIG_W +: DIG_W] >= DIG_W'(5)) begin
        adj[i*DIG_W +: DIG_W] = bcd_i[i*DIG_W +: DIG_W] + DIG_W'(3);
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_i[i*DIG_W +: DIG_W];
      end
    end
  end

  assign bcd_o = {adj[BCD_W-2:0], bit_i};

endmodule
`default_nettype wire

// ----- rtl/core/iff_out_stage.sv -----
// Output register that holds one character until the consumer takes it.
`default_nettype none
module iff_out_stage
  import iff_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire iff_out_t push_data,
  output logic          space,
  output logic          out_valid,
  input  wire logic     out_ready,
  output iff_out_t      out_data
);

  logic     valid_r;
  logic     valid_nxt;
  iff_out_t data_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/iff_checker.sv -----
// Port-level checks on the integer field formatter and their binding.
`default_nettype none
`include "integer_field_formatter_macros.svh"
module iff_checker
  import iff_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire iff_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire iff_out_t out_data
);

  `IFF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled character changed")
  `IFF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")
  `IFF_ASSERT_IMP(a_no_overlap, out_valid && !out_data.last, !in_ready, "request taken mid field")
  `IFF_ASSERT_IMP(a_printable, out_valid, (out_data.out_char >= CH_SPACE) && (out_data.out_char <= 8'h7a), "character out of range")

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);
`default_nettype wire
